// ===== rtl/lkvc_pkg.sv =====
// Shared types, sizes and helper functions for the LRU key/value cache.
// No dependencies; used by lkvc_scan and lru_key_value_cache_top.
package lkvc_pkg;

  // Store geometry
  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 32;
  localparam int DATA_W   = 32;
  localparam int CAP_W    = 5;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef logic [IDX_W-1:0]    slot_t;
  typedef logic [IDX_W-1:0]    rank_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [DATA_W-1:0]   data_t;
  typedef logic [CMP_W-1:0]    cmp_t;

  // Operation codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Registered outcome of one pass over the store
  typedef struct packed {
    logic  hit;
    slot_t hit_slot;
    slot_t lru0;       // slot holding rank count-1
    slot_t lru1;       // slot holding rank count-2
    slot_t free_slot;  // first empty slot
  } scan_res_t;

  // One result item
  typedef struct packed {
    logic  hit;
    data_t read_value;
    logic  evicted;
    data_t evicted_key;
    data_t evicted_value;
  } result_t;

  // Sign-extend a 32-bit key, keep KEY_BITS bits
  function automatic key_t to_key(logic [31:0] k);
    logic [63:0] ext;
    ext = {{32{k[31]}}, k};
    return ext[KEY_BITS-1:0];
  endfunction

  // Stored key back to a 32-bit result field
  function automatic data_t from_key(key_t k);
    logic [63:0] t;
    t = 64'(k);
    return t[DATA_W-1:0];
  endfunction

  // Clamp the capacity register to 1..ENTRIES
  function automatic cmp_t eff_cap(logic [CAP_W-1:0] c);
    cmp_t ce;
    ce = CMP_W'(c);
    if (ce == '0) ce = CMP_W'(1);
    if (ce > CMP_W'(ENTRIES)) ce = CMP_W'(ENTRIES);
    return ce;
  endfunction

endpackage

// ===== rtl/lru_key_value_cache_top.sv =====
// Fully associative key/value cache with least-recently-used replacement.
// Depends on lkvc_pkg and lkvc_scan.

// A get returns the stored value on a hit and makes that entry most recent;
// a put updates or inserts and, when the held count exceeds the capacity
// register, evicts the least recent entry and reports its key and value.
// A transfer is accepted in the idle state; in the scan state the single
// key comparator then walks all ENTRIES (16) slots one by one, and the
// update state loads the output register, or a done state holds the result
// while that register is occupied. The block accepts no new item until it
// is idle again. The store is empty after reset; the capacity register
// resets to 16, a write of 0 acts as 1 and values above 16 act as 16.
module lru_key_value_cache_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_cmd,
  input  logic signed [31:0]               in_lookup_key,
  input  logic signed [31:0]               in_store_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_hit,
  output logic signed [31:0]               out_read_value,
  output logic                             out_evicted,
  output logic signed [31:0]               out_evicted_key,
  output logic signed [31:0]               out_evicted_value,
  // capacity register
  input  logic                             cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0]       cfg_wr_data
);
  import lkvc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  localparam slot_t LAST_IDX = IDX_W'(ENTRIES - 1);

  // Store
  key_t                keys_r   [ENTRIES];
  data_t               values_r [ENTRIES];
  rank_t               rank_r   [ENTRIES];
  logic [ENTRIES-1:0]  valid_r;
  cnt_t                count_r;
  logic [CAP_W-1:0]    cap_r;

  // Sequencer and captured item
  state_t  state_r, state_nxt;
  slot_t   idx_r;
  logic    cmd_r;
  key_t    key_r;
  data_t   val_r;

  // Results
  result_t res_r, res_nxt, out_r;
  logic    out_valid_r;

  scan_res_t scan;

  // Update-cycle signals
  rank_t              rank_nxt [ENTRIES];
  logic [ENTRIES-1:0] valid_nxt;
  cnt_t               count_nxt;
  cmp_t               cap;
  cmp_t               cnt_cmp;
  logic               is_put;
  logic               ev_hit, ev_miss, do_evict, do_insert;
  slot_t              ev_slot, ins_slot, key_rd_idx, val_rd_idx;
  rank_t              touch_rank;
  key_t               key_rd;
  data_t              val_rd;
  logic               out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CAP_W'(16);
    else if (cfg_wr_en) cap_r <= cfg_wr_data;
  end

  // Shared key comparator
  lkvc_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_valid && in_ready),
    .step       (state_r == ST_SCAN),
    .idx        (idx_r),
    .slot_valid (valid_r[idx_r]),
    .slot_key   (key_rd),
    .slot_rank  (rank_r[idx_r]),
    .key        (key_r),
    .count      (count_r),
    .res        (scan)
  );

  // Eviction and insertion decisions
  always_comb begin
    cap        = eff_cap(cap_r);
    cnt_cmp    = CMP_W'(count_r);
    is_put     = (cmd_r == CMD_PUT);
    ev_hit     = is_put && scan.hit && (cnt_cmp > cap);
    ev_miss    = is_put && !scan.hit &&
                 ((cnt_cmp >= cap) || (count_r >= CNT_W'(ENTRIES)));
    do_evict   = ev_hit || ev_miss;
    do_insert  = is_put && !scan.hit;
    // touching the old LRU entry promotes the next one
    ev_slot    = (ev_hit && (scan.hit_slot == scan.lru0)) ? scan.lru1 : scan.lru0;
    ins_slot   = ev_miss ? ev_slot : scan.free_slot;
    touch_rank = rank_r[scan.hit_slot];
    key_rd_idx = (state_r == ST_UPDATE) ? ev_slot : idx_r;
    val_rd_idx = is_put ? ev_slot : scan.hit_slot;
  end

  // Single read port per array
  assign key_rd = keys_r[key_rd_idx];
  assign val_rd = values_r[val_rd_idx];

  // Recency and occupancy update
  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < ENTRIES; i++) rank_nxt[i] = rank_r[i];
    if (scan.hit) begin
      for (int i = 0; i < ENTRIES; i++)
        if (valid_r[i] && (rank_r[i] < touch_rank)) rank_nxt[i] = rank_r[i] + IDX_W'(1);
      rank_nxt[scan.hit_slot] = '0;
    end
    if (do_evict) begin
      valid_nxt[ev_slot] = 1'b0;
      rank_nxt[ev_slot]  = '0;
    end
    if (do_insert) begin
      for (int i = 0; i < ENTRIES; i++)
        if (valid_nxt[i]) rank_nxt[i] = rank_nxt[i] + IDX_W'(1);
      valid_nxt[ins_slot] = 1'b1;
      rank_nxt[ins_slot]  = '0;
    end
    count_nxt = count_r - CNT_W'(do_evict) + CNT_W'(do_insert);
  end

  // Result of the update cycle
  always_comb begin
    res_nxt.hit           = scan.hit;
    res_nxt.read_value    = (!is_put && scan.hit) ? val_rd : '0;
    res_nxt.evicted       = do_evict;
    res_nxt.evicted_key   = do_evict ? from_key(key_rd) : '0;
    res_nxt.evicted_value = do_evict ? val_rd : '0;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (idx_r == LAST_IDX) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = out_free ? ST_IDLE : ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE)      idx_r <= '0;
      else if (state_r == ST_SCAN) idx_r <= idx_r + IDX_W'(1);
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
      key_r <= to_key(in_lookup_key);
      val_r <= in_store_value;
    end
  end

  // Control part of the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
    end else if (state_r == ST_UPDATE) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= rank_nxt[i];
    end
  end

  // Key and value arrays
  always_ff @(posedge clk) begin
    if ((state_r == ST_UPDATE) && is_put) begin
      if (scan.hit) begin
        values_r[scan.hit_slot] <= val_r;
      end else begin
        keys_r[ins_slot]   <= key_r;
        values_r[ins_slot] <= val_r;
      end
    end
  end

  // Held result while the output register is occupied
  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) res_r <= res_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_UPDATE) && out_free) begin
      out_valid_r <= 1'b1;
      out_r       <= res_nxt;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
      out_r       <= res_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_r.hit;
  assign out_read_value    = out_r.read_value;
  assign out_evicted       = out_r.evicted;
  assign out_evicted_key   = out_r.evicted_key;
  assign out_evicted_value = out_r.evicted_value;

  // Occupancy count tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_r)))
    else $error("entry count differs from number of valid slots");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count above store size");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready high right after an input transfer");

  a_evict_only_put: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && !is_put) |-> !do_evict)
    else $error("get caused an eviction");

endmodule

// ===== rtl/lkvc_scan.sv =====
// Shared compare unit: walks the store one slot per cycle and records the
// matching slot, the two least recent slots and the first free slot.
// Depends on lkvc_pkg.
module lkvc_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              step,
  input  lkvc_pkg::slot_t   idx,
  input  logic              slot_valid,
  input  lkvc_pkg::key_t    slot_key,
  input  lkvc_pkg::rank_t   slot_rank,
  input  lkvc_pkg::key_t    key,
  input  lkvc_pkg::cnt_t    count,
  output lkvc_pkg::scan_res_t res
);
  import lkvc_pkg::*;

  scan_res_t res_r;
  logic      free_found_r;

  logic             match;
  logic             is_lru0;
  logic             is_lru1;
  logic [CNT_W:0]   rank_ext;
  logic [CNT_W:0]   cnt_ext;

  // Per-slot compares
  assign rank_ext = (CNT_W + 1)'(slot_rank);
  assign cnt_ext  = (CNT_W + 1)'(count);
  assign match    = slot_valid && (slot_key == key);
  assign is_lru0  = slot_valid && (rank_ext + (CNT_W + 1)'(1) == cnt_ext);
  assign is_lru1  = slot_valid && (rank_ext + (CNT_W + 1)'(2) == cnt_ext);

  // Accumulate the pass results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r        <= '0;
      free_found_r <= 1'b0;
    end else if (start) begin
      res_r        <= '0;
      free_found_r <= 1'b0;
    end else if (step) begin
      if (match && !res_r.hit) begin
        res_r.hit      <= 1'b1;
        res_r.hit_slot <= idx;
      end
      if (is_lru0) res_r.lru0 <= idx;
      if (is_lru1) res_r.lru1 <= idx;
      if (!slot_valid && !free_found_r) begin
        res_r.free_slot <= idx;
        free_found_r    <= 1'b1;
      end
    end
  end

  assign res = res_r;

  // A match is only ever recorded once per pass
  a_hit_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.hit && !start) |=> res_r.hit)
    else $error("scan hit flag dropped mid-pass");

  a_hit_slot_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.hit && !start) |=> $stable(res_r.hit_slot))
    else $error("scan hit slot changed after first match");

  a_free_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (free_found_r && !start) |=> $stable(res_r.free_slot))
    else $error("scan free slot changed after first empty slot");

endmodule

// ===== sim/lru_key_value_cache_top_test.sv =====
// Self-checking testbench for lru_key_value_cache_top: directed and random get/put traffic
// with capacity changes, checked against an LRU store model kept in a scoreboard class.
// Depends on lkvc_pkg and the cache RTL only.
`timescale 1ns / 1ps

module lru_key_value_cache_top_test;
  import lkvc_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 160;
  localparam int NUM_PHASES   = 8;
  localparam int REPORT_LIMIT = 10;
  localparam int EXP_DEPTH    = 64;

  // Scoreboard: keeps its own copy of the cache contents and recency order
  class cache_scoreboard;
    key_t        slot_key[ENTRIES];
    data_t       slot_value[ENTRIES];
    bit          slot_used[ENTRIES];
    int unsigned slot_age[ENTRIES];
    int          held;
    logic [CAP_W-1:0] capacity;
    result_t     expected_ring[EXP_DEPTH];
    int unsigned ring_wr;
    int unsigned ring_rd;
    int          failures;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_used[i]  = 1'b0;
        slot_age[i]   = 0;
      end
      held     = 0;
      capacity = CAP_W'(16);
      ring_wr  = 0;
      ring_rd  = 0;
      failures = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int pending();
      return int'(ring_wr - ring_rd);
    endfunction

    // Move slot s to the front of the recency order
    function void promote(int s);
      int unsigned r;
      r = slot_age[s];
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
      slot_age[s] = 0;
    endfunction

    // Drop the least recent entry and report it in r
    function void evict_oldest(inout result_t r);
      int oldest;
      oldest = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) oldest = i;
      if (oldest < 0) return;
      r.evicted       = 1'b1;
      r.evicted_key   = data_t'(slot_key[oldest]);
      r.evicted_value = slot_value[oldest];
      slot_used[oldest] = 1'b0;
      slot_age[oldest]  = 0;
      if (held > 0) held--;
    endfunction

    // Apply one get or put to the model and return the response it must produce
    function result_t predict_access(logic cmd, logic [31:0] key_in, logic [31:0] value);
      result_t     r;
      logic [63:0] ext;
      key_t        k;
      int          limit;
      int          found;
      int          spot;
      ext = {{32{key_in[31]}}, key_in};
      k   = ext[KEY_BITS-1:0];
      r   = '0;
      limit = int'(capacity);
      if (limit < 1) limit = 1;
      if (limit > ENTRIES) limit = ENTRIES;

      found = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (found < 0 && slot_used[i] && slot_key[i] == k) found = i;

      if (cmd == CMD_GET) begin
        if (found >= 0) begin
          r.hit        = 1'b1;
          r.read_value = slot_value[found];
          promote(found);
        end
        return r;
      end

      // put on a present key: overwrite, refresh, trim if over capacity
      if (found >= 0) begin
        r.hit = 1'b1;
        slot_value[found] = value;
        promote(found);
        if (held > limit) evict_oldest(r);
        return r;
      end

      // put on a new key: make room if needed, then insert as most recent
      if (held + 1 > limit || held >= ENTRIES) evict_oldest(r);
      spot = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (spot < 0 && !slot_used[i]) spot = i;
      if (spot < 0) return r;
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i]) slot_age[i]++;
      slot_used[spot]  = 1'b1;
      slot_key[spot]   = k;
      slot_value[spot] = value;
      slot_age[spot]   = 0;
      held++;
      return r;
    endfunction

    function void note_request(logic cmd, logic [31:0] key_in, logic [31:0] value);
      expected_ring[ring_wr % EXP_DEPTH] = predict_access(cmd, key_in, value);
      ring_wr++;
    endfunction

    function void check_response(result_t got);
      result_t want;
      if (ring_wr == ring_rd) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: unexpected response hit=%0b rd=%h ev=%0b key=%h val=%h", $realtime,
                   got.hit, got.read_value, got.evicted, got.evicted_key, got.evicted_value);
        return;
      end
      want = expected_ring[ring_rd % EXP_DEPTH];
      ring_rd++;
      if (got !== want) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t: response mismatch", $realtime);
          $display("  exp hit=%0b rd=%h ev=%0b key=%h val=%h", want.hit, want.read_value,
                   want.evicted, want.evicted_key, want.evicted_value);
          $display("  got hit=%0b rd=%h ev=%0b key=%h val=%h", got.hit, got.read_value,
                   got.evicted, got.evicted_key, got.evicted_value);
        end
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_cmd = CMD_GET;
  logic signed [31:0]      in_lookup_key = '0;
  logic signed [31:0]      in_store_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_hit;
  logic signed [31:0]      out_read_value;
  logic                    out_evicted;
  logic signed [31:0]      out_evicted_key;
  logic signed [31:0]      out_evicted_value;
  logic                    cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]        cfg_wr_data = '0;

  cache_scoreboard sb;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles = 0;
  logic [31:0] key_pool[24];

  lru_key_value_cache_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_lookup_key     (in_lookup_key),
    .in_store_value    (in_store_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_read_value    (out_read_value),
    .out_evicted       (out_evicted),
    .out_evicted_key   (out_evicted_key),
    .out_evicted_value (out_evicted_value),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Result-side backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Monitor both channels; watchdog on cycles without any transfer
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_hit, out_read_value, out_evicted, out_evicted_key, out_evicted_value};
      sb.check_response(got);
    end
    if (rst_n && in_valid && in_ready)
      sb.note_request(in_cmd, in_lookup_key, in_store_value);
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL lru_key_value_cache_top");
      $finish;
    end
  end

  // Present one request and hold it until the transfer happens
  task automatic send_request(input logic cmd, input logic [31:0] key, input logic [31:0] value);
    // sender idles cycle by cycle before presenting the item
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_lookup_key  <= key;
    in_store_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every response is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    // let the monitor note the last transfer first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_capacity(c);
  endtask

  initial begin
    int phase_cap[NUM_PHASES];
    int phase_span[NUM_PHASES];
    int phase_send[NUM_PHASES];
    int phase_stall[NUM_PHASES];
    logic [31:0] key;
    logic        cmd;

    phase_cap   = '{1, 0, 31, 4, 16, 8, 3, 12};
    phase_span  = '{5, 5, 20, 8, 20, 12, 7, 16};
    phase_send  = '{0, 63, 0, 30, 0, 63, 0, 30};
    phase_stall = '{0, 0, 63, 30, 0, 0, 63, 30};

    sb = new();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 24; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty miss, key/value extremes, hit, update, miss
    send_request(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(CMD_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
    send_request(CMD_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(CMD_PUT, 32'h8000_0000, 32'h0000_0000);
    send_request(CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_GET, 32'h0000_0000, 32'h0);
    send_request(CMD_GET, 32'h8000_0000, 32'h0);
    send_request(CMD_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
    send_request(CMD_GET, 32'h0000_0005, 32'h0);
    // fill to 16 entries, then a new key into the full store
    for (int i = 0; i < 12; i++) send_request(CMD_PUT, 32'd100 + i, $urandom);
    send_request(CMD_PUT, 32'd200, 32'hA5A5_5A5A);
    send_request(CMD_GET, 32'h8000_0000, 32'h0);
    wait_drained();

    // capacity lowered below the held count: gets never evict, puts trim one at a time
    write_capacity(CAP_W'(2));
    send_request(CMD_GET, 32'd200, 32'h0);
    send_request(CMD_PUT, 32'd200, 32'h5A5A_A5A5);
    send_request(CMD_PUT, 32'd300, 32'hDEAD_BEEF);
    wait_drained();

    // Random phases over capacity settings and idle patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(CAP_W'(phase_cap[p]));
      sender_idle_pct    = phase_send[p];
      receiver_stall_pct = phase_stall[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        cmd = $urandom_range(1) ? CMD_PUT : CMD_GET;
        if ($urandom_range(99) < 85) key = key_pool[$urandom_range(phase_span[p] - 1)];
        else key = $urandom;
        send_request(cmd, key, $urandom);
      end
      wait_drained();
    end

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (40) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS lru_key_value_cache_top");
    end else begin
      $display("FAIL lru_key_value_cache_top");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lkvc_pkg.sv
rtl/lkvc_scan.sv
rtl/lru_key_value_cache_top.sv
sim/lru_key_value_cache_top_test.sv
